// ===== rtl/mctb_pkg.sv =====
// Shared types and codes for the multi-channel timer bank.
// Used by the timer cell and the top level; depends on nothing.
package mctb_pkg;

   // Command codes
   localparam logic [2:0] CMD_ALLOC   = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_STOP    = 3'd2;
   localparam logic [2:0] CMD_RESTART = 3'd3;
   localparam logic [2:0] CMD_FREE    = 3'd4;
   localparam logic [2:0] CMD_PROCESS = 3'd5;
   localparam logic [2:0] CMD_QUERY   = 3'd6;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_ZERO_IVL = 2'd2;
   localparam logic [1:0] ST_NO_FREE  = 2'd3;

   // Control part of the token that walks down the cell row
   typedef struct packed {
      logic       valid;
      logic [2:0] req_type;
      logic [3:0] channel;
      logic       is_periodic;
      logic       found;
      logic [1:0] status;
      logic [3:0] handle;
   } token_type;

endpackage

// ===== rtl/mctb_cell.sv =====
// One timer channel: holds its flags, reload and deadline, acts on the
// passing token and hands it on through a register. Depends on mctb_pkg.
module mctb_cell #(
   parameter int NUM_CHANNELS = 16,
   parameter int TIME_BITS    = 32,
   parameter int IDX          = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mctb_pkg::token_type        tok_in,
   input  logic [TIME_BITS-1:0]       interval_in,
   input  logic [TIME_BITS-1:0]       now_in,
   input  logic [TIME_BITS-1:0]       min_in,
   input  logic [TIME_BITS-1:0]       rem_in,
   input  logic [NUM_CHANNELS-1:0]    mask_in,
   output mctb_pkg::token_type        tok_out,
   output logic [TIME_BITS-1:0]       interval_out,
   output logic [TIME_BITS-1:0]       now_out,
   output logic [TIME_BITS-1:0]       min_out,
   output logic [TIME_BITS-1:0]       rem_out,
   output logic [NUM_CHANNELS-1:0]    mask_out
);
   import mctb_pkg::*;

   logic                    alloc_ff, alloc_in;
   logic                    armed_ff, armed_in;
   logic                    per_ff, per_in;
   logic [TIME_BITS-1:0]    reload_ff, reload_in;
   logic [TIME_BITS-1:0]    dl_ff, dl_in;
   token_type               tok_ff, tok_nx;
   logic [TIME_BITS-1:0]    ivl_ff, now_ff, min_ff, rem_ff, min_nx, rem_nx;
   logic [NUM_CHANNELS-1:0] mask_ff, mask_nx;
   logic                    hit;
   logic [TIME_BITS-1:0]    rearm;

   assign hit   = (32'(tok_in.channel) == 32'(IDX));
   assign rearm = now_in + reload_ff;

   // Apply the command to this channel and fold it into the token
   always_comb begin
      alloc_in  = alloc_ff;
      armed_in  = armed_ff;
      per_in    = per_ff;
      reload_in = reload_ff;
      dl_in     = dl_ff;
      tok_nx    = tok_in;
      rem_nx    = rem_in;
      mask_nx   = mask_in;
      if (tok_in.valid) begin
         case (tok_in.req_type)
            CMD_ALLOC: begin
               if (interval_in != '0 && !tok_in.found && !alloc_ff) begin
                  alloc_in      = 1'b1;
                  armed_in      = 1'b0;
                  per_in        = tok_in.is_periodic;
                  reload_in     = interval_in;
                  tok_nx.found  = 1'b1;
                  tok_nx.status = ST_OK;
                  tok_nx.handle = 4'(IDX);
               end
            end
            CMD_START, CMD_RESTART: begin
               if (hit && alloc_ff) begin
                  dl_in         = rearm;
                  armed_in      = 1'b1;
                  tok_nx.status = ST_OK;
               end
            end
            CMD_STOP: begin
               if (hit && armed_ff) begin
                  armed_in      = 1'b0;
                  tok_nx.status = ST_OK;
               end
            end
            CMD_FREE: begin
               if (hit) begin
                  alloc_in = 1'b0;
                  armed_in = 1'b0;
               end
            end
            CMD_PROCESS: begin
               if (armed_ff && now_in >= dl_ff) begin
                  if (per_ff) dl_in = rearm;
                  else armed_in = 1'b0;
                  mask_nx[IDX] = 1'b1;
               end
            end
            CMD_QUERY: begin
               if (hit && armed_ff) begin
                  tok_nx.status = ST_OK;
                  rem_nx = (now_in < dl_ff) ? dl_ff - now_in : '0;
               end
            end
            default: begin
               tok_nx.status = ST_INVALID;
            end
         endcase
      end
      // carry the running minimum over the updated state
      min_nx = (armed_in && dl_in < min_in) ? dl_in : min_in;
   end

   // Hold channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= 1'b0;
         armed_ff <= 1'b0;
         per_ff   <= 1'b0;
         tok_ff   <= '0;
      end else begin
         alloc_ff <= alloc_in;
         armed_ff <= armed_in;
         per_ff   <= per_in;
         tok_ff   <= tok_nx;
      end
   end

   // Advance the token payload
   always_ff @(posedge clock) begin
      reload_ff <= reload_in;
      dl_ff     <= dl_in;
      ivl_ff    <= interval_in;
      now_ff    <= now_in;
      min_ff    <= min_nx;
      rem_ff    <= rem_nx;
      mask_ff   <= mask_nx;
   end

   assign tok_out      = tok_ff;
   assign interval_out = ivl_ff;
   assign now_out      = now_ff;
   assign min_out      = min_ff;
   assign rem_out      = rem_ff;
   assign mask_out     = mask_ff;

endmodule

// ===== rtl/multi_channel_timer_bank_top.sv =====
// Multi-channel timer bank. One command is taken at a time; it walks a row
// of NUM_CHANNELS timer cells, one cell per cycle, each cell registering the
// token. When the token leaves the last cell its results are captured and
// offered one by one; the result side can stall each of them. The next
// command is taken the cycle after the last result leaves. Process-expiry
// commands give one result per expired channel in ascending order (a single
// one when none expired), each carrying the earliest armed deadline after
// the scan (all ones when none is armed).
// Depends on mctb_pkg and mctb_cell.
module multi_channel_timer_bank_top #(
   parameter int NUM_CHANNELS = 16,
   parameter int TIME_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[2:0], channel[6:3], reload_ms[38:7], is_periodic[39], now_ms[71:40]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], handle[5:2], expired_valid[6], expired_channel[10:7],
   // remaining_ms[42:11], earliest_expiry[74:43], zero fill [79:75]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast
);
   import mctb_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]              state_ff, state_in;
   token_type               tok [NUM_CHANNELS+1];
   logic [TIME_BITS-1:0]    ivl [NUM_CHANNELS+1];
   logic [TIME_BITS-1:0]    now [NUM_CHANNELS+1];
   logic [TIME_BITS-1:0]    mn  [NUM_CHANNELS+1];
   logic [TIME_BITS-1:0]    rem [NUM_CHANNELS+1];
   logic [NUM_CHANNELS-1:0] msk [NUM_CHANNELS+1];

   logic [2:0]              r_type;
   logic [3:0]              r_ch;
   logic [TIME_BITS-1:0]    r_ivl;
   logic                    accept;
   logic [1:0]              init_status;
   token_type               head_tok;

   logic [2:0]              cmd_ff;
   logic [1:0]              status_ff;
   logic [3:0]              handle_ff;
   logic [TIME_BITS-1:0]    rem_ff, min_ff;
   logic [NUM_CHANNELS-1:0] mask_ff, mask_in, low_bit;
   logic [3:0]              xch;
   logic                    is_proc, xv, last;

   assign r_type = req_tdata[2:0];
   assign r_ch   = req_tdata[6:3];
   assign r_ivl  = TIME_BITS'(req_tdata[38:7]);
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Status before any cell claims the command
   always_comb begin
      case (r_type)
         CMD_ALLOC:   init_status = (r_ivl == '0) ? ST_ZERO_IVL : ST_NO_FREE;
         CMD_FREE:    init_status = (32'(r_ch) < 32'(NUM_CHANNELS)) ? ST_OK : ST_INVALID;
         CMD_PROCESS: init_status = ST_OK;
         default:     init_status = ST_INVALID;
      endcase
   end

   // Build the token for the head of the row
   always_comb begin
      head_tok.valid       = accept;
      head_tok.req_type    = r_type;
      head_tok.channel     = r_ch;
      head_tok.is_periodic = req_tdata[39];
      head_tok.found       = 1'b0;
      head_tok.status      = init_status;
      head_tok.handle      = 4'd0;
   end

   // Inject the token at the head of the row
   assign tok[0] = head_tok;
   assign ivl[0] = r_ivl;
   assign now[0] = TIME_BITS'(req_tdata[71:40]);
   assign mn[0]  = '1;
   assign rem[0] = '0;
   assign msk[0] = '0;

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
      mctb_cell #(
         .NUM_CHANNELS(NUM_CHANNELS),
         .TIME_BITS   (TIME_BITS),
         .IDX         (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_in      (tok[g]),
         .interval_in (ivl[g]),
         .now_in      (now[g]),
         .min_in      (mn[g]),
         .rem_in      (rem[g]),
         .mask_in     (msk[g]),
         .tok_out     (tok[g+1]),
         .interval_out(ivl[g+1]),
         .now_out     (now[g+1]),
         .min_out     (mn[g+1]),
         .rem_out     (rem[g+1]),
         .mask_out    (msk[g+1])
      );
   end

   // Pick the lowest expired channel
   assign low_bit = mask_ff & (~mask_ff + 1'b1);
   always_comb begin
      xch = 4'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (low_bit[i]) xch = 4'(i);
      end
   end

   assign is_proc = (cmd_ff == CMD_PROCESS);
   assign xv      = is_proc && (mask_ff != '0);
   assign last    = !xv || ((mask_ff & ~low_bit) == '0);

   // Sequence idle, scan and result phases
   always_comb begin
      state_in = state_ff;
      mask_in  = mask_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_SCAN;
         S_SCAN: if (tok[NUM_CHANNELS].valid) begin
            state_in = S_EMIT;
            mask_in  = msk[NUM_CHANNELS];
         end
         S_EMIT: if (rsp_tready) begin
            mask_in = mask_ff & ~low_bit;
            if (last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // Capture the finished token
   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (state_ff == S_SCAN && tok[NUM_CHANNELS].valid) begin
         cmd_ff    <= tok[NUM_CHANNELS].req_type;
         status_ff <= tok[NUM_CHANNELS].status;
         handle_ff <= tok[NUM_CHANNELS].handle;
         rem_ff    <= rem[NUM_CHANNELS];
         min_ff    <= mn[NUM_CHANNELS];
      end
   end

   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tlast  = last;
   assign rsp_tdata  = {5'd0, 32'(min_ff), 32'(rem_ff), xch, xv, handle_ff, status_ff};

endmodule

// ===== rtl/mctb_checker.sv =====
// Port-level checks for the timer bank, bound to the top level.
// Depends on multi_channel_timer_bank_top's port list only.
module mctb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);
   // never take a command while results are pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");

   // one command at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");

   // a result without an expired channel closes the run
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tlast) else $error("non-expiry not last");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind multi_channel_timer_bank_top mctb_checker u_mctb_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
